/* hdl/qft_pkg.sv */
package qft_pkg;

    // Source length limit; offsets and lengths saturate against it.
    localparam longint unsigned SOURCE_LIMIT = 64'd65536;
    localparam int unsigned     SET_SLOTS    = 8;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 16;
    localparam int unsigned LEN_W  = 17;
    localparam int unsigned SET_W  = 64;

    localparam longint unsigned POS_CAP_L =
        (SOURCE_LIMIT - 64'd1 < 64'hFFFF) ? SOURCE_LIMIT - 64'd1 : 64'hFFFF;
    localparam longint unsigned LEN_CAP_L =
        (SOURCE_LIMIT < 64'h1FFFF) ? SOURCE_LIMIT : 64'h1FFFF;
    localparam logic [POS_W-1:0] POS_CAP = POS_CAP_L[POS_W-1:0];
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_CAP_L[LEN_W-1:0];

    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h5C;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER_SET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHITESPACE_SET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE_SET      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_ENABLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESS_EMPTY = 3'd4;

    localparam logic [SET_W-1:0] DELIMITER_SET_RST  = 64'd44;
    localparam logic [SET_W-1:0] WHITESPACE_SET_RST = 64'h0D0A0920;
    localparam logic [SET_W-1:0] QUOTE_SET_RST      = 64'd34;

    // Result queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned FIFO_CW    = FIFO_AW + 1;

    typedef struct packed {
        logic [POS_W-1:0]  token_start;
        logic [LEN_W-1:0]  token_length;
        logic [BYTE_W-1:0] ending_delimiter;
        logic              last_token;
    } result_t;

    // Zero never matches; zero slots are unused.
    function automatic logic in_set(input logic [SET_W-1:0] set, input logic [BYTE_W-1:0] b);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < SET_SLOTS; i++) begin
            if ((b != '0) && (set[BYTE_W*i +: BYTE_W] == b)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

/* hdl/quoted_field_tokenizer.sv */
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_stall    source_byte, is_last
// out      source     out_valid / out_stall  token_start, token_length,
//                                            ending_delimiter, last_token
// cfg      sink       cfg_we                 cfg_index, cfg_data
//
// One source byte is taken per cycle; its token work is done in the cycle it
// is accepted and the results (none, one or two) land in a four-entry queue.
// in_stall rises while fewer than two queue entries are free, so the rate is
// one byte per cycle as long as the output side takes one result per cycle.
// A result is written into the queue when its byte is accepted and shows on out once the results ahead of it are taken.
// Reset (rst_n low, asynchronous) empties the queue, clears the token state
// and loads the register reset values.
module quoted_field_tokenizer
    import qft_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    source_byte,
    input  logic                 is_last,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [POS_W-1:0]     token_start,
    output logic [LEN_W-1:0]     token_length,
    output logic [BYTE_W-1:0]    ending_delimiter,
    output logic                 last_token,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SET_W-1:0]     cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SET_W-1:0] delim_set_reg;
    logic [SET_W-1:0] ws_set_reg;
    logic [SET_W-1:0] quote_set_reg;
    logic             trim_reg;
    logic             compress_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_set_reg <= DELIMITER_SET_RST;
            ws_set_reg    <= WHITESPACE_SET_RST;
            quote_set_reg <= QUOTE_SET_RST;
            trim_reg      <= 1'b0;
            compress_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DELIMITER_SET:  delim_set_reg <= cfg_data;
                REG_WHITESPACE_SET: ws_set_reg    <= cfg_data;
                REG_QUOTE_SET:      quote_set_reg <= cfg_data;
                REG_TRIM_ENABLE:    trim_reg      <= cfg_data[0];
                REG_COMPRESS_EMPTY: compress_reg  <= cfg_data[0];
                default:            ;   // unknown index: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Token state
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [POS_W-1:0]  start_reg, start_next;
    logic [LEN_W-1:0]  len_reg,   len_next;
    logic [LEN_W-1:0]  pend_reg,  pend_next;    // trailing unquoted whitespace
    logic [BYTE_W-1:0] quote_reg, quote_next;   // open quote byte, 0 if none
    logic              esc_reg,   esc_next;
    logic              given_reg, given_next;   // a token already given

    logic    in_accept;
    logic    is_delim, is_quote, is_ws;
    logic    do_count, ended;
    logic [LEN_W-1:0] tok_len;
    result_t res_a, res_b;
    logic    res_a_valid, res_b_valid;

    assign in_accept = in_valid && !in_stall;

    assign is_delim = in_set(delim_set_reg, source_byte);
    assign is_quote = in_set(quote_set_reg, source_byte);
    assign is_ws    = in_set(ws_set_reg, source_byte);

    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        pend_next  = pend_reg;
        quote_next = quote_reg;
        esc_next   = esc_reg;
        given_next = given_reg;
        pos_next   = pos_reg;
        do_count   = 1'b0;
        ended      = 1'b0;

        // Byte role, in priority order: escaped, backslash, delimiter,
        // closing quote, opening quote, whitespace, ordinary.
        if (esc_reg)
        begin
            do_count = 1'b1;
            esc_next = 1'b0;
        end
        else if (source_byte == ESCAPE_BYTE)
        begin
            do_count  = 1'b1;
            pend_next = '0;
            esc_next  = 1'b1;
        end
        else if ((quote_reg == '0) && is_delim)
        begin
            ended = 1'b1;
        end
        else if ((quote_reg != '0) && (source_byte == quote_reg))
        begin
            quote_next = '0;
            do_count   = 1'b1;
        end
        else if ((quote_reg == '0) && is_quote)
        begin
            quote_next = source_byte;
            pend_next  = '0;
            do_count   = 1'b1;
        end
        else if (trim_reg)
        begin
            if ((quote_reg == '0) && is_ws)
            begin
                // leading whitespace is dropped, inner whitespace held back
                if (len_reg != '0)
                begin
                    if (pend_reg < LEN_CAP)
                    begin
                        pend_next = pend_reg + LEN_W'(1);
                    end
                    do_count = 1'b1;
                end
            end
            else
            begin
                pend_next = '0;
                do_count  = 1'b1;
            end
        end
        else
        begin
            do_count = 1'b1;
        end

        if (do_count)
        begin
            if (len_reg == '0)
            begin
                start_next = pos_reg;
            end
            if (len_reg < LEN_CAP)
            begin
                len_next = len_reg + LEN_W'(1);
            end
        end

        // Token as it stands after this byte (unchanged when a delimiter ends it)
        tok_len = (len_next > pend_next) ? len_next - pend_next : '0;

        res_a.token_start      = (tok_len == '0) ? '0 : start_next;
        res_a.token_length     = tok_len;
        res_a.ending_delimiter = ended ? source_byte : '0;
        res_a.last_token       = !ended && is_last;

        if (ended)
        begin
            res_a_valid = !((tok_len == '0) && compress_reg && given_reg);
        end
        else
        begin
            res_a_valid = is_last;   // end of source: always given
        end

        // Delimiter as last byte: a final empty token follows
        res_b.token_start      = '0;
        res_b.token_length     = '0;
        res_b.ending_delimiter = '0;
        res_b.last_token       = 1'b1;
        res_b_valid            = ended && is_last;

        if (res_a_valid)
        begin
            given_next = 1'b1;
        end

        if (ended || is_last)
        begin
            start_next = '0;
            len_next   = '0;
            pend_next  = '0;
            quote_next = '0;
            esc_next   = 1'b0;
        end

        if (is_last)
        begin
            pos_next   = '0;
            given_next = 1'b0;
        end
        else if (pos_reg < POS_CAP)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            pend_reg  <= '0;
            quote_reg <= '0;
            esc_reg   <= 1'b0;
            given_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
            quote_reg <= quote_next;
            esc_reg   <= esc_next;
            given_reg <= given_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: up to two writes per cycle, one read
    // ------------------------------------------------------------------
    result_t              fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg,  count_next;
    logic                 push_0, push_1, pop;
    result_t              push_0_data;
    logic [FIFO_AW-1:0]   wr_ptr_plus1;
    logic [FIFO_CW-1:0]   push_cnt;

    assign in_stall  = count_reg > FIFO_CW'(FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign pop       = out_valid && !out_stall;

    // a lone second result takes the first slot
    assign push_0      = in_accept && (res_a_valid || res_b_valid);
    assign push_1      = in_accept && res_a_valid && res_b_valid;
    assign push_0_data = res_a_valid ? res_a : res_b;
    assign wr_ptr_plus1 = wr_ptr_reg + FIFO_AW'(1);

    always_comb
    begin
        push_cnt    = FIFO_CW'(push_0) + FIFO_CW'(push_1);
        wr_ptr_next = wr_ptr_reg + push_cnt[FIFO_AW-1:0];
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + push_cnt - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_0)
        begin
            fifo_reg[wr_ptr_reg] <= push_0_data;
        end
        if (push_1)
        begin
            fifo_reg[wr_ptr_plus1] <= res_b;
        end
    end

    assign token_start      = fifo_reg[rd_ptr_reg].token_start;
    assign token_length     = fifo_reg[rd_ptr_reg].token_length;
    assign ending_delimiter = fifo_reg[rd_ptr_reg].ending_delimiter;
    assign last_token       = fifo_reg[rd_ptr_reg].last_token;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue over-filled");

    a_room_for_two: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> count_reg <= FIFO_CW'(FIFO_DEPTH - 2))
        else $error("item accepted without room for two results");

    a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && is_last |=> (pos_reg == '0) && (len_reg == '0) && !given_reg)
        else $error("state not cleared after end of source");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && is_last |=> count_reg != '0)
        else $error("end of source gave no result");
`endif

endmodule
